/* rtl/vbe_pkg.sv */
package vbe_pkg;

  // Register file sizing
  localparam int unsigned REGISTER_COUNT_DEF = 10;
  localparam int unsigned REG_STORE_MAX      = 16;
  localparam int unsigned REG_IDX_W          = 4;

  // Configuration
  localparam int unsigned VRAM_W             = 29;
  localparam logic [VRAM_W-1:0] VRAM_RESET   = 29'd16777216;

  // Mode window register indices
  localparam logic [REG_IDX_W-1:0] IDX_ID         = 4'd0;
  localparam logic [REG_IDX_W-1:0] IDX_XRES       = 4'd1;
  localparam logic [REG_IDX_W-1:0] IDX_YRES       = 4'd2;
  localparam logic [REG_IDX_W-1:0] IDX_BPP        = 4'd3;
  localparam logic [REG_IDX_W-1:0] IDX_ENABLE     = 4'd4;
  localparam logic [REG_IDX_W-1:0] IDX_VIRT_WIDTH = 4'd6;
  localparam logic [REG_IDX_W-1:0] IDX_X_OFFSET   = 4'd8;
  localparam logic [REG_IDX_W-1:0] IDX_Y_OFFSET   = 4'd9;
  localparam logic [6:0]           IDX_MEM64K     = 7'd10;

  // Fixed read values
  localparam logic [15:0] ID_WORD      = 16'hB0C5;
  localparam logic [15:0] BAD_IDX_WORD = 16'hFFFF;
  localparam logic [31:0] EXT_SIZE     = 32'd8;

  // Extension window
  localparam logic [7:0]  EXT_OFF_SIZE  = 8'd0;
  localparam logic [7:0]  EXT_OFF_ORDER = 8'd4;
  localparam logic [31:0] MAGIC_BIG     = 32'hBEBEBEBE;
  localparam logic [31:0] MAGIC_LITTLE  = 32'h1E1E1E1E;

  // Mode decode limits
  localparam logic [15:0] BPP_16    = 16'd16;
  localparam logic [15:0] BPP_32    = 16'd32;
  localparam logic [15:0] MIN_DIM   = 16'd64;

  typedef enum logic [1:0] {
    ACC_MODE_RD = 2'd0,
    ACC_MODE_WR = 2'd1,
    ACC_EXT_RD  = 2'd2,
    ACC_EXT_WR  = 2'd3
  } access_t;

  typedef enum logic [1:0] {
    FMT_NONE      = 2'd0,
    FMT_RGB565    = 2'd1,
    FMT_XRGB_LE   = 2'd2,
    FMT_XRGB_BE   = 2'd3
  } pixel_format_t;

  // Register contents the decoder needs
  typedef struct packed {
    logic [15:0] xres;
    logic [15:0] yres;
    logic [15:0] bpp;
    logic        enable;
    logic [15:0] vwidth;
    logic [15:0] x_offset;
    logic [15:0] y_offset;
    logic        big_endian;
  } mode_state_t;

endpackage

/* rtl/vbe_access.sv */
module vbe_access #(
  parameter int unsigned REGISTER_COUNT = vbe_pkg::REGISTER_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [1:0]                      mode,
  input  logic [7:0]                      address,
  input  logic [31:0]                     write_data,
  input  logic [vbe_pkg::VRAM_W-1:0]      vram_bytes,
  output logic                            rd_valid,
  output logic [31:0]                     rd_data,
  output vbe_pkg::mode_state_t            state
);
  import vbe_pkg::*;

  localparam int unsigned IDX_W     = $clog2(REGISTER_COUNT);
  localparam logic [6:0]  IDX_LIMIT = 7'(REGISTER_COUNT);

  // input stage
  logic        s1_valid;
  access_t     s1_mode;
  logic [7:0]  s1_address;
  logic [31:0] s1_write_data;

  logic [15:0] mode_regs [REGISTER_COUNT];
  logic        big_endian;

  logic [6:0]  idx;
  logic        idx_ok;
  logic        reg_wr;
  logic        order_wr;
  logic        big_endian_next;
  logic [15:0] regs_view [REGISTER_COUNT];
  logic [31:0] rd_data_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_mode       <= access_t'(mode);
      s1_address    <= address;
      s1_write_data <= write_data;
    end
  end

  assign idx      = s1_address[7:1];
  assign idx_ok   = idx < IDX_LIMIT;
  assign reg_wr   = s1_valid && s1_mode == ACC_MODE_WR && idx_ok;
  assign order_wr = s1_valid && s1_mode == ACC_EXT_WR && s1_address == EXT_OFF_ORDER;

  always_comb begin
    rd_data_next = '0;
    case (s1_mode)
      ACC_MODE_RD: begin
        if (idx == 7'(IDX_ID)) begin
          rd_data_next = {16'd0, ID_WORD};
        end else if (idx == IDX_MEM64K) begin
          rd_data_next = 32'(vram_bytes[VRAM_W-1:16]);
        end else if (!idx_ok) begin
          rd_data_next = {16'd0, BAD_IDX_WORD};
        end else begin
          rd_data_next = {16'd0, mode_regs[idx[IDX_W-1:0]]};
        end
      end
      ACC_EXT_RD: begin
        if (s1_address == EXT_OFF_SIZE) begin
          rd_data_next = EXT_SIZE;
        end else if (s1_address == EXT_OFF_ORDER) begin
          rd_data_next = big_endian ? MAGIC_BIG : MAGIC_LITTLE;
        end
      end
      default: rd_data_next = '0;
    endcase
  end

  // only the exact magic words move the byte-order flag
  always_comb begin
    big_endian_next = big_endian;
    if (order_wr) begin
      if (s1_write_data == MAGIC_BIG) begin
        big_endian_next = 1'b1;
      end else if (s1_write_data == MAGIC_LITTLE) begin
        big_endian_next = 1'b0;
      end
    end
  end

  // register file and byte-order flag
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < int'(REGISTER_COUNT); i++) begin
        mode_regs[i] <= '0;
      end
      big_endian <= 1'b0;
    end else begin
      if (reg_wr) begin
        mode_regs[idx[IDX_W-1:0]] <= s1_write_data[15:0];
      end
      big_endian <= big_endian_next;
    end
  end

  assign rd_valid = s1_valid;
  assign rd_data  = rd_data_next;

  // register contents with this transfer's write already applied
  always_comb begin
    for (int i = 0; i < int'(REGISTER_COUNT); i++) begin
      regs_view[i] = mode_regs[i];
    end
    if (reg_wr) begin
      regs_view[idx[IDX_W-1:0]] = s1_write_data[15:0];
    end
  end

  always_comb begin
    state.xres       = regs_view[IDX_XRES];
    state.yres       = regs_view[IDX_YRES];
    state.bpp        = regs_view[IDX_BPP];
    state.enable     = regs_view[IDX_ENABLE][0];
    state.vwidth     = regs_view[IDX_VIRT_WIDTH];
    state.x_offset   = regs_view[IDX_X_OFFSET];
    state.y_offset   = regs_view[IDX_Y_OFFSET];
    state.big_endian = big_endian_next;
  end

endmodule

/* rtl/vbe_decode.sv */
module vbe_decode (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_valid,
  input  logic [31:0]                 rd_data,
  input  vbe_pkg::mode_state_t        state,
  input  logic [vbe_pkg::VRAM_W-1:0]  vram_bytes,
  output logic                        done,
  output logic [31:0]                 read_data,
  output logic                        mode_valid,
  output logic [1:0]                  pixel_format,
  output logic [15:0]                 frame_width,
  output logic [15:0]                 frame_height,
  output logic [17:0]                 line_stride,
  output logic [33:0]                 frame_offset,
  output logic [33:0]                 frame_size
);
  import vbe_pkg::*;

  logic          bpp16;
  logic          bpp32;
  logic [15:0]   virt;
  logic [17:0]   stride;
  logic [17:0]   x_bytes;
  logic [33:0]   size;
  logic [33:0]   y_bytes;
  logic [33:0]   offset;
  logic [34:0]   end_byte;
  logic          ok;
  pixel_format_t fmt;

  always_comb begin
    bpp16    = state.bpp == BPP_16;
    bpp32    = state.bpp == BPP_32;
    virt     = (state.vwidth < state.xres) ? state.xres : state.vwidth;
    stride   = bpp32 ? {virt, 2'b00} : {1'b0, virt, 1'b0};
    x_bytes  = bpp32 ? {state.x_offset, 2'b00} : {1'b0, state.x_offset, 1'b0};
    size     = 34'(stride) * 34'(state.yres);
    y_bytes  = 34'(stride) * 34'(state.y_offset);
    offset   = y_bytes + 34'(x_bytes);
    end_byte = 35'(offset) + 35'(size);
    ok       = state.enable && (bpp16 || bpp32) &&
               state.xres >= MIN_DIM && state.yres >= MIN_DIM &&
               end_byte <= 35'(vram_bytes);
    if (bpp16) begin
      fmt = FMT_RGB565;
    end else if (state.big_endian) begin
      fmt = FMT_XRGB_BE;
    end else begin
      fmt = FMT_XRGB_LE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rd_valid;
    end
    if (rd_valid) begin
      read_data    <= rd_data;
      mode_valid   <= ok;
      pixel_format <= ok ? fmt : FMT_NONE;
      frame_width  <= ok ? state.xres : '0;
      frame_height <= ok ? state.yres : '0;
      line_stride  <= ok ? stride : '0;
      frame_offset <= ok ? offset : '0;
      frame_size   <= ok ? size : '0;
    end
  end

endmodule

/* rtl/vbe_display_register_file.sv */
// A taken transfer passes the command and result registers; done is high with its result.
// One transfer every cycle unless busy; busy is high in reset and the cycle after it.
// Reset (rst, synchronous, active high) clears the mode registers, selects little endian,
// and sets video memory size to 16 MiB; no result is in flight afterwards.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
module vbe_display_register_file #(
  parameter int unsigned REGISTER_COUNT = vbe_pkg::REGISTER_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  mode,
  input  logic [7:0]                  address,
  input  logic [31:0]                 write_data,
  // configuration channel: video memory size in bytes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [vbe_pkg::VRAM_W-1:0]  cfg_data,
  // result
  output logic                        done,
  output logic [31:0]                 read_data,
  output logic                        mode_valid,
  output logic [1:0]                  pixel_format,
  output logic [15:0]                 frame_width,
  output logic [15:0]                 frame_height,
  output logic [17:0]                 line_stride,
  output logic [33:0]                 frame_offset,
  output logic [33:0]                 frame_size
);
  import vbe_pkg::*;

  // Pipeline:
  //   stage 1 - command register (vbe_access)
  //   between the registers - read mux, register view with this transfer's write
  //   folded in, and the mode decode on that view
  //   stage 2 - result register (vbe_decode); the register file is written on the same edge
  // Each transfer sees all writes of earlier transfers and its own, since the decode
  // works on the register contents with the current write already applied.

  logic               accept;
  logic [VRAM_W-1:0]  vram_bytes;
  logic               rd_valid;
  logic [31:0]        rd_data;
  mode_state_t        state;

  // busy only covers reset and the cycle straight after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  // Video memory size, used as written (no rounding)
  always_ff @(posedge clk) begin
    if (rst) begin
      vram_bytes <= VRAM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vram_bytes <= cfg_data;
    end
  end

  vbe_access #(
    .REGISTER_COUNT(REGISTER_COUNT)
  ) u_access (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .mode       (mode),
    .address    (address),
    .write_data (write_data),
    .vram_bytes (vram_bytes),
    .rd_valid   (rd_valid),
    .rd_data    (rd_data),
    .state      (state)
  );

  vbe_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .rd_valid     (rd_valid),
    .rd_data      (rd_data),
    .state        (state),
    .vram_bytes   (vram_bytes),
    .done         (done),
    .read_data    (read_data),
    .mode_valid   (mode_valid),
    .pixel_format (pixel_format),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .line_stride  (line_stride),
    .frame_offset (frame_offset),
    .frame_size   (frame_size)
  );

  // Every taken transfer yields a result through the command and result registers
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 done)
    else $error("transfer taken without result two cycles later");

  // No result without a matching earlier transfer taken
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 2))
    else $error("result without matching transfer");

  // An invalid mode reports all mode fields as zero
  a_invalid_mode_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !mode_valid) |-> (pixel_format == FMT_NONE && frame_width == '0 &&
      frame_height == '0 && line_stride == '0 && frame_offset == '0 && frame_size == '0))
    else $error("mode fields not cleared for invalid mode");

  // A valid mode never reports a frame below the minimum size or no pixel format
  a_valid_mode_dims: assert property (@(posedge clk) disable iff (rst)
    (done && mode_valid) |-> (frame_width >= MIN_DIM && frame_height >= MIN_DIM &&
      pixel_format != FMT_NONE))
    else $error("valid mode with bad geometry or format");

endmodule

/* sim/tb_vbe_display_register_file.sv */
`timescale 1ns / 1ps

module tb_vbe_display_register_file;
  import vbe_pkg::*;

  localparam int unsigned REG_COUNT    = REGISTER_COUNT_DEF;
  localparam int          IDLE_LIMIT   = 1000;  // cycles with no transfer of any kind
  localparam int          DRAIN_CYCLES = 6;     // margin past the command and result registers
  localparam int          PRINT_CAP    = 40;    // mismatch lines printed, all are counted
  localparam int          RANDOM_ITEMS = 1320;
  localparam int          PHASE_ITEMS  = 200;   // random accesses between memory-size changes

  // One expected result: read data plus the decoded display mode
  typedef struct {
    logic [31:0]   read_data;
    logic          mode_valid;
    pixel_format_t fmt;
    logic [15:0]   width;
    logic [15:0]   height;
    logic [17:0]   stride;
    logic [33:0]   offset;
    logic [33:0]   size;
  } access_result_t;

  logic clk = 1'b0;
  logic rst;

  logic               start;
  logic               busy;
  logic [1:0]         mode;
  logic [7:0]         address;
  logic [31:0]        write_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [VRAM_W-1:0]  cfg_data;
  logic               done;
  logic [31:0]        read_data;
  logic               mode_valid;
  logic [1:0]         pixel_format;
  logic [15:0]        frame_width;
  logic [15:0]        frame_height;
  logic [17:0]        line_stride;
  logic [33:0]        frame_offset;
  logic [33:0]        frame_size;

  // Shadow copy of the register file, kept in step with every accepted transfer
  logic [15:0]        shadow_regs [REG_STORE_MAX];
  logic               shadow_big_endian;
  logic [VRAM_W-1:0]  shadow_vram;
  access_result_t     pending_results [$];

  int  error_count       = 0;
  int  accesses_sent     = 0;
  int  results_checked   = 0;
  int  valid_modes_seen  = 0;
  int  vram_writes       = 0;
  int  idle_cycles       = 0;
  bit  burst_mode        = 1'b0;  // when set, start is held high with no gaps

  always #5 clk = ~clk;

  vbe_display_register_file #(
    .REGISTER_COUNT(REG_COUNT)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .address     (address),
    .write_data  (write_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .done        (done),
    .read_data   (read_data),
    .mode_valid  (mode_valid),
    .pixel_format(pixel_format),
    .frame_width (frame_width),
    .frame_height(frame_height),
    .line_stride (line_stride),
    .frame_offset(frame_offset),
    .frame_size  (frame_size)
  );

  // ---------------------------------------------------------------------------
  // Mode decode from the shadow registers. Everything stays zero unless the
  // mode is enabled, 16 or 32 bpp, at least 64x64 and fits in video memory.
  // Arithmetic is done at 64 bits so the fit check cannot wrap.
  // ---------------------------------------------------------------------------
  function automatic access_result_t decode_display_mode();
    access_result_t r;
    logic [63:0]    bytes_pp, w, h, v, strd, sz, offs;
    pixel_format_t  f;
    r.read_data  = '0;
    r.mode_valid = 1'b0;
    r.fmt        = FMT_NONE;
    r.width      = '0;
    r.height     = '0;
    r.stride     = '0;
    r.offset     = '0;
    r.size       = '0;
    if (shadow_regs[IDX_ENABLE][0] == 1'b0) return r;
    if (shadow_regs[IDX_BPP] == BPP_16) begin
      bytes_pp = 64'd2;
      f        = FMT_RGB565;
    end else if (shadow_regs[IDX_BPP] == BPP_32) begin
      bytes_pp = 64'd4;
      f        = shadow_big_endian ? FMT_XRGB_BE : FMT_XRGB_LE;
    end else begin
      return r;  // unknown colour depth
    end
    w = 64'(shadow_regs[IDX_XRES]);
    h = 64'(shadow_regs[IDX_YRES]);
    v = 64'(shadow_regs[IDX_VIRT_WIDTH]);
    if (v < w) v = w;  // stride follows the wider of virtual and visible width
    strd = v * bytes_pp;
    sz   = strd * h;
    offs = 64'(shadow_regs[IDX_X_OFFSET]) * bytes_pp + 64'(shadow_regs[IDX_Y_OFFSET]) * strd;
    if (w < 64'(MIN_DIM) || h < 64'(MIN_DIM)) return r;
    if (offs + sz > 64'(shadow_vram)) return r;
    r.mode_valid = 1'b1;
    r.fmt        = f;
    r.width      = w[15:0];
    r.height     = h[15:0];
    r.stride     = strd[17:0];
    r.offset     = offs[33:0];
    r.size       = sz[33:0];
    return r;
  endfunction

  // Applies one bus access to the shadow state and returns what the block owes
  function automatic access_result_t predict_access(access_t acc, logic [7:0] addr,
                                                    logic [31:0] data);
    access_result_t r;
    logic [6:0]     idx;
    logic [31:0]    rd;
    idx = addr[7:1];
    rd  = '0;
    case (acc)
      ACC_MODE_RD: begin
        if (idx == 7'(IDX_ID))
          rd = 32'(ID_WORD);
        else if (idx == IDX_MEM64K)
          rd = 32'(shadow_vram >> 16);  // memory size in 64 KiB units
        else if (idx >= REG_COUNT || idx >= REG_STORE_MAX)
          rd = 32'(BAD_IDX_WORD);
        else
          rd = 32'(shadow_regs[idx[3:0]]);
      end
      ACC_MODE_WR: begin
        // writes past the register count vanish; index 0 is stored but never read back
        if (idx < REG_COUNT && idx < REG_STORE_MAX) shadow_regs[idx[3:0]] = data[15:0];
      end
      ACC_EXT_RD: begin
        if (addr == EXT_OFF_SIZE)
          rd = EXT_SIZE;
        else if (addr == EXT_OFF_ORDER)
          rd = shadow_big_endian ? MAGIC_BIG : MAGIC_LITTLE;
      end
      default: begin
        // only the exact magic words at the byte-order offset count
        if (addr == EXT_OFF_ORDER) begin
          if (data == MAGIC_BIG)
            shadow_big_endian = 1'b1;
          else if (data == MAGIC_LITTLE)
            shadow_big_endian = 1'b0;
        end
      end
    endcase
    r           = decode_display_mode();
    r.read_data = rd;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting and the per-field compare
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_CAP) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [33:0] got,
                             input logic [33:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  task automatic check_result();
    access_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result strobe with no access outstanding");
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    if (want.mode_valid) valid_modes_seen++;
    check_field("read_data",    34'(read_data),    34'(want.read_data));
    check_field("mode_valid",   34'(mode_valid),   34'(want.mode_valid));
    check_field("pixel_format", 34'(pixel_format), 34'(want.fmt));
    check_field("frame_width",  34'(frame_width),  34'(want.width));
    check_field("frame_height", 34'(frame_height), 34'(want.height));
    check_field("line_stride",  34'(line_stride),  34'(want.stride));
    check_field("frame_offset", frame_offset,      want.offset);
    check_field("frame_size",   frame_size,        want.size);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: all sampling happens here at the rising edge, before the block's
  // own updates land. Results are checked before the new transfer is queued.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_STORE_MAX; i++) shadow_regs[i] = '0;
      shadow_big_endian = 1'b0;
      shadow_vram       = VRAM_RESET;
      pending_results.delete();
    end else begin
      if (done) check_result();
      if (start && !busy)
        pending_results.push_back(predict_access(access_t'(mode), address, write_data));
      if (cfg_valid && cfg_ready) shadow_vram = cfg_data;
    end
  end

  // Watchdog: any transfer on any channel resets the count
  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus tasks. All are entered and left at a falling edge.
  // ---------------------------------------------------------------------------

  // One command transfer, preceded by a random gap unless in a burst.
  // start is left high on return; the next call either keeps it or drops it.
  task automatic put_access(input access_t acc, input logic [7:0] addr,
                            input logic [31:0] data);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      = 1'b1;
    mode       = acc;
    address    = addr;
    write_data = data;
    @(posedge clk);
    while (busy) @(posedge clk);
    accesses_sent++;
    @(negedge clk);
  endtask

  // Mode-window write with random junk in the upper half, which must be dropped
  task automatic write_mode_reg(input logic [3:0] idx, input logic [15:0] val);
    logic [31:0] noise;
    noise = $urandom;
    put_access(ACC_MODE_WR, {3'b000, idx, 1'b0}, {noise[31:16], val});
  endtask

  // Stop issuing and wait until every outstanding result has come back
  task automatic settle();
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_vram(input logic [VRAM_W-1:0] bytes);
    settle();
    cfg_data  = bytes;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    vram_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Biased register values: mostly plausible modes, some out of range
  function automatic logic [15:0] pick_reg_value(input logic [3:0] idx);
    logic [31:0] r;
    int          sel;
    r   = $urandom;
    sel = $urandom_range(0, 7);
    case (idx)
      IDX_XRES, IDX_YRES: begin
        case (sel)
          0:       return 16'($urandom_range(0, 63));
          1:       return r[15:0];
          2:       return MIN_DIM;
          default: return 16'($urandom_range(64, 2048));
        endcase
      end
      IDX_BPP: begin
        if (sel < 4) return BPP_32;
        if (sel < 7) return BPP_16;
        return r[15:0];
      end
      IDX_ENABLE: begin
        if (sel == 0) return r[15:0];
        return {r[15:1], 1'b1};
      end
      IDX_VIRT_WIDTH: begin
        if (sel < 4) return 16'd0;
        if (sel < 7) return 16'($urandom_range(0, 4096));
        return r[15:0];
      end
      IDX_X_OFFSET, IDX_Y_OFFSET: begin
        if (sel < 3) return 16'd0;
        if (sel < 7) return 16'($urandom_range(0, 255));
        return r[15:0];
      end
      default: return r[15:0];
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Identity word, memory size, reads and writes beyond the register count,
  // and the fixed extension-window words
  task automatic test_fixed_reads();
    put_access(ACC_MODE_RD, 8'h00, 32'h0);
    put_access(ACC_MODE_RD, 8'h01, 32'hFFFF_FFFF);        // odd byte, same index
    put_access(ACC_MODE_RD, {IDX_MEM64K, 1'b0}, 32'h0);
    put_access(ACC_MODE_RD, 8'hFF, 32'h0);                // far past the registers
    put_access(ACC_MODE_WR, 8'h16, 32'hFFFF_FFFF);        // ignored write
    put_access(ACC_MODE_RD, 8'h16, 32'h0);
    write_mode_reg(IDX_ID, 16'hFFFF);                     // stored, identity still reads
    put_access(ACC_MODE_RD, 8'h00, 32'h0);
    put_access(ACC_EXT_RD, EXT_OFF_SIZE, 32'h0);
    put_access(ACC_EXT_RD, 8'hFF, 32'h0);
  endtask

  // Byte-order word: exact magic only, right offset only
  task automatic test_byte_order();
    put_access(ACC_EXT_RD, EXT_OFF_ORDER, 32'h0);
    put_access(ACC_EXT_WR, EXT_OFF_ORDER, MAGIC_BIG);
    put_access(ACC_EXT_RD, EXT_OFF_ORDER, 32'h0);
    put_access(ACC_EXT_WR, EXT_OFF_ORDER, MAGIC_LITTLE ^ 32'h8000_0000);
    put_access(ACC_EXT_WR, EXT_OFF_SIZE, MAGIC_LITTLE);
    put_access(ACC_EXT_RD, EXT_OFF_ORDER, 32'h0);
  endtask

  // Mode decode corners at the reset memory size (16 MiB); big endian is set
  task automatic test_mode_decode();
    write_mode_reg(IDX_XRES, MIN_DIM);
    write_mode_reg(IDX_YRES, MIN_DIM);
    write_mode_reg(IDX_BPP, BPP_32);
    write_mode_reg(IDX_ENABLE, 16'h0001);                 // smallest legal mode
    write_mode_reg(IDX_XRES, MIN_DIM - 16'd1);            // too narrow
    write_mode_reg(IDX_XRES, 16'hFFFF);                   // widest stride, just fits
    write_mode_reg(IDX_YRES, MIN_DIM + 16'd1);            // one line too many
    write_mode_reg(IDX_BPP, BPP_16);
    write_mode_reg(IDX_BPP, 16'd24);                      // unsupported depth
    write_mode_reg(IDX_BPP, BPP_32);
    put_access(ACC_EXT_WR, EXT_OFF_ORDER, MAGIC_LITTLE);
    write_mode_reg(IDX_XRES, 16'd640);
    write_mode_reg(IDX_Y_OFFSET, 16'hFFFF);               // origin far beyond memory
    put_access(ACC_MODE_RD, {3'b000, IDX_Y_OFFSET, 1'b0}, 32'h0);
  endtask

  // Memory size register at 4 MiB, 256 MiB and sizes between. Each setting gets a
  // 1024-wide mode whose footprint sits on the edge of memory, as far as 65535 lines allow.
  task automatic test_vram_settings();
    int unsigned sizes [6] = '{32'd4194304, 32'd268435456, 32'd8388608,
                               32'd33554432, 32'd134217728, 32'd16777216};
    int unsigned lines;
    foreach (sizes[i]) begin
      set_vram(sizes[i][VRAM_W-1:0]);
      lines = sizes[i] / 4096;
      if (lines > 65535) lines = 65535;
      put_access(ACC_MODE_RD, {IDX_MEM64K, 1'b0}, 32'h0);
      write_mode_reg(IDX_XRES, 16'd1024);
      write_mode_reg(IDX_YRES, lines[15:0]);
      write_mode_reg(IDX_BPP, BPP_32);
      write_mode_reg(IDX_VIRT_WIDTH, 16'd0);
      write_mode_reg(IDX_X_OFFSET, 16'd0);
      write_mode_reg(IDX_Y_OFFSET, 16'd0);
      write_mode_reg(IDX_ENABLE, 16'h0001);
      write_mode_reg(IDX_Y_OFFSET, 16'd1);                // one line lower
      write_mode_reg(IDX_X_OFFSET, 16'd1);                // and one pixel across
    end
  endtask

  // Mostly complete mode set-ups with random content, mixed with raw noise
  // accesses and byte-order traffic. The memory size and the gap pattern
  // change every phase.
  task automatic test_random_traffic(input int count);
    logic [3:0]  seq [7] = '{IDX_XRES, IDX_YRES, IDX_BPP, IDX_VIRT_WIDTH,
                             IDX_X_OFFSET, IDX_Y_OFFSET, IDX_ENABLE};
    int          target;
    int          phase_start;
    int          pick;
    int          extra;
    logic [3:0]  idx;
    logic [31:0] data;
    logic [7:0]  addr;
    target      = accesses_sent + count;
    phase_start = accesses_sent;
    while (accesses_sent < target) begin
      if (accesses_sent - phase_start >= PHASE_ITEMS) begin
        set_vram(29'(32'd1 << $urandom_range(22, 28)));
        burst_mode  = ($urandom_range(0, 2) == 0);
        phase_start = accesses_sent;
      end
      pick = $urandom_range(0, 9);
      data = $urandom;
      addr = 8'($urandom_range(0, 255));
      if (pick < 6) begin
        foreach (seq[i]) write_mode_reg(seq[i], pick_reg_value(seq[i]));
        extra = $urandom_range(0, 2);
        repeat (extra) begin
          idx = 4'($urandom_range(0, 15));
          write_mode_reg(idx, pick_reg_value(idx));
        end
        put_access(ACC_MODE_RD, 8'($urandom_range(0, 31)), data);
      end else if (pick < 8) begin
        put_access(access_t'($urandom_range(0, 3)), addr, data);
      end else if (pick == 8) begin
        case ($urandom_range(0, 3))
          0:       data = MAGIC_BIG;
          1:       data = MAGIC_LITTLE;
          2:       data = MAGIC_BIG ^ (32'd1 << $urandom_range(0, 31));
          default: ;
        endcase
        put_access(ACC_EXT_WR, ($urandom_range(0, 3) == 0) ? addr : EXT_OFF_ORDER, data);
        put_access(ACC_EXT_RD, 8'($urandom_range(0, 7)), $urandom);
      end else begin
        put_access(ACC_MODE_RD, addr, data);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    mode       = ACC_MODE_RD;
    address    = '0;
    write_data = '0;
    cfg_valid  = 1'b0;
    cfg_data   = VRAM_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_fixed_reads();
    test_byte_order();
    test_mode_decode();
    test_vram_settings();
    test_random_traffic(RANDOM_ITEMS);

    settle();
    $display("Covered %0d register accesses, %0d results checked, %0d with a valid mode.",
             accesses_sent, results_checked, valid_modes_seen);
    $display("Memory size written %0d times; %0d mismatches.", vram_writes, error_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
